### rtl/mrt_pkg.sv
// Shared types, sizes and codes of the memory region table.
package mrt_pkg;

  localparam int ENTRIES    = 16;
  localparam int ADDR_BITS  = 48;
  localparam int KIND_COUNT = 6;

  localparam int FIELD_W = 48;
  localparam int KIND_W  = 3;
  localparam int OWNER_W = 8;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 4;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int USED_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W   = 10;
  localparam int SUM_W   = FIELD_W + 1;

  localparam logic [FIELD_W-1:0] ADDR_MASK = FIELD_W'((65'(1) << ADDR_BITS) - 65'(1));
  localparam logic [64:0] ADDR_LIMIT = 65'(1) << ADDR_BITS;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPLIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADARG  = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERLAP = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOCONT  = 3'd4;
  localparam logic [STAT_W-1:0] ST_SHAPE   = 3'd5;
  localparam logic [STAT_W-1:0] ST_INDEX   = 3'd6;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] length;
    logic [KIND_W-1:0]  kind;
    logic [OWNER_W-1:0] owner;
  } entry_t;

endpackage

### rtl/mrt_if.sv
// Request and response channel interfaces of the memory region table.
interface mrt_req_if;
  logic                             valid;
  logic                             ready;
  logic [mrt_pkg::MODE_W-1:0]       mode;
  logic [mrt_pkg::FIELD_W-1:0]      region_base;
  logic [mrt_pkg::FIELD_W-1:0]      region_length;
  logic [mrt_pkg::KIND_W-1:0]       region_kind;
  logic [mrt_pkg::OWNER_W-1:0]      owner_id;
  logic [mrt_pkg::INDEX_W-1:0]      entry_index;

  modport source (output valid, mode, region_base, region_length, region_kind, owner_id,
                  entry_index, input ready);
  modport sink   (input valid, mode, region_base, region_length, region_kind, owner_id,
                  entry_index, output ready);
endinterface

interface mrt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mrt_pkg::STAT_W-1:0]       status;
  logic [mrt_pkg::FIELD_W-1:0]      entry_base;
  logic [mrt_pkg::FIELD_W-1:0]      entry_length;
  logic [mrt_pkg::KIND_W-1:0]       entry_kind;
  logic [mrt_pkg::OWNER_W-1:0]      entry_owner;
  logic [mrt_pkg::COUNT_W-1:0]      entry_count;

  modport source (output valid, status, entry_base, entry_length, entry_kind, entry_owner,
                  entry_count, input ready);
  modport sink   (input valid, status, entry_base, entry_length, entry_kind, entry_owner,
                  entry_count, output ready);
endinterface

### rtl/mrt_cell.sv
// One table cell: holds a single region entry, shifts from its neighbor or takes a write.
module mrt_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  mrt_pkg::entry_t shift_data_i,
  input  logic            wr_en_i,
  input  mrt_pkg::entry_t wr_data_i,
  output mrt_pkg::entry_t entry_o
);

  mrt_pkg::entry_t entry_q;

  // write wins; shift only while the ring rotates
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_data_i;
    end else if (shift_i) begin
      entry_q <= shift_data_i;
    end
  end

  assign entry_o = entry_q;

endmodule

### rtl/memory_region_table.sv
// Top level of the memory region table: cell ring, scan sequencer and response register.
//
// Usage: a request transaction on req_i carries a mode (add, split or read), a range
// (region_base, region_length), a type code, an owner and an entry index. Exactly one
// response transaction on rsp_o answers each request with a status code, the entry read
// (zero unless a read succeeds) and the number of stored entries afterward.
// The entries live in a ring of ENTRIES cells. For every request the ring rotates once,
// one cell per cycle, so each stored entry passes the head comparator in insertion order:
// overlap checks, the container search and the read capture all happen there.
// From acceptance to rsp_o.valid the sequencer forms the range end, scans the ring,
// takes the decision, writes the cells and loads the response; the request fields latch
// at the accepting edge itself. A new request is accepted only in the idle state, after
// the previous one has loaded its response, a pace set by the single head comparator.
// req_i.ready is high only while the sequencer is idle; the response register lets the
// next request be accepted while an earlier response still waits.
// If the receiver stalls, the response holds stable and a finished request waits in the
// load step until the register frees up.
// Reset clears the entry count, the sequencer and the response register; cell contents
// are left as they are and are never read before they are written.
module memory_region_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrt_req_if.sink   req_i,
  mrt_rsp_if.source rsp_o
);

  localparam int N = mrt_pkg::ENTRIES;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SCAN, S_DECIDE, S_WRITE, S_DONE
  } state_e;

  state_e state_q;
  logic [mrt_pkg::USED_W-1:0] used_q;

  // latched request
  logic [mrt_pkg::MODE_W-1:0]  mode_q;
  logic [mrt_pkg::FIELD_W-1:0] base_q;
  logic [mrt_pkg::FIELD_W-1:0] len_q;
  logic [mrt_pkg::KIND_W-1:0]  kind_q;
  logic [mrt_pkg::OWNER_W-1:0] owner_q;
  logic [mrt_pkg::INDEX_W-1:0] idx_q;

  logic [mrt_pkg::SUM_W-1:0]   new_end_q;
  logic                        badarg_q;
  logic [mrt_pkg::IDX_W-1:0]   k_q;

  // scan results
  logic                        ovl_q;
  logic                        found_q;
  logic [mrt_pkg::IDX_W-1:0]   cap_idx_q;
  mrt_pkg::entry_t             cap_q;
  logic [mrt_pkg::SUM_W-1:0]   cap_end_q;
  mrt_pkg::entry_t             rd_q;

  // decision
  logic [mrt_pkg::STAT_W-1:0]  stat_q, stat_d;
  logic                        do_mod_q, do_mod_d;
  logic                        do_tail_q, do_tail_d;
  logic                        do_new_q, do_new_d;
  mrt_pkg::entry_t             mod_q, mod_d;
  mrt_pkg::entry_t             tail_q, tail_d;

  // response register
  logic                        rsp_valid_q;
  logic [mrt_pkg::STAT_W-1:0]  rsp_status_q;
  mrt_pkg::entry_t             rsp_entry_q;
  logic [mrt_pkg::COUNT_W-1:0] rsp_count_q;

  // cell ring
  mrt_pkg::entry_t             cell_out [N];
  mrt_pkg::entry_t             cell_wr  [N];
  logic [N-1:0]                cell_we;
  logic                        shift;

  assign shift = (state_q == S_SCAN);

  for (genvar i = 0; i < N; i++) begin : g_cell
    mrt_cell u_cell (
      .clk_i        (clk_i),
      .shift_i      (shift),
      .shift_data_i (cell_out[(i + 1) % N]),
      .wr_en_i      (cell_we[i]),
      .wr_data_i    (cell_wr[i]),
      .entry_o      (cell_out[i])
    );
  end

  // head of the ring: entry k_q during the scan
  mrt_pkg::entry_t             head;
  logic [mrt_pkg::SUM_W-1:0]   head_end;
  logic                        head_used;
  logic                        head_ovl;
  logic                        head_holds;

  assign head       = cell_out[0];
  assign head_end   = {1'b0, head.base} + {1'b0, head.length};
  assign head_used  = mrt_pkg::CMP_W'(k_q) < mrt_pkg::CMP_W'(used_q);
  assign head_ovl   = ({1'b0, base_q} < head_end) && ({1'b0, head.base} < new_end_q);
  assign head_holds = (base_q >= head.base) && (new_end_q <= head_end);

  // decide status and planned writes from the scan results and the captured container
  logic                        free1, free2;
  logic                        whole, front, middle;
  logic                        idx_ok;
  mrt_pkg::entry_t             new_e;

  assign free1  = mrt_pkg::CMP_W'(used_q) < mrt_pkg::CMP_W'(N);
  assign free2  = mrt_pkg::CMP_W'(used_q) + mrt_pkg::CMP_W'(2) <= mrt_pkg::CMP_W'(N);
  assign front  = (base_q == cap_q.base);
  assign whole  = front && (new_end_q == cap_end_q);
  assign middle = (new_end_q < cap_end_q);
  assign idx_ok = mrt_pkg::CMP_W'(idx_q) < mrt_pkg::CMP_W'(used_q);
  assign new_e  = '{base: base_q, length: len_q, kind: kind_q, owner: owner_q};

  always_comb begin
    stat_d    = mrt_pkg::ST_BADARG;
    do_mod_d  = 1'b0;
    do_tail_d = 1'b0;
    do_new_d  = 1'b0;
    mod_d     = cap_q;
    tail_d    = '{base: new_end_q[mrt_pkg::FIELD_W-1:0],
                  length: mrt_pkg::FIELD_W'(cap_end_q - new_end_q),
                  kind: cap_q.kind, owner: cap_q.owner};
    case (mode_q)
      mrt_pkg::MODE_ADD: begin
        if (badarg_q) begin
          stat_d = mrt_pkg::ST_BADARG;
        end else if (ovl_q) begin
          stat_d = mrt_pkg::ST_OVERLAP;
        end else if (!free1) begin
          stat_d = mrt_pkg::ST_FULL;
        end else begin
          stat_d   = mrt_pkg::ST_OK;
          do_new_d = 1'b1;
        end
      end
      mrt_pkg::MODE_SPLIT: begin
        if (badarg_q) begin
          stat_d = mrt_pkg::ST_BADARG;
        end else if (!found_q) begin
          stat_d = mrt_pkg::ST_NOCONT;
        end else if (whole) begin
          // retype only; owner stays
          stat_d     = mrt_pkg::ST_OK;
          do_mod_d   = 1'b1;
          mod_d.kind = kind_q;
        end else if (front) begin
          stat_d = free1 ? mrt_pkg::ST_OK : mrt_pkg::ST_FULL;
          do_mod_d     = free1;
          do_new_d     = free1;
          mod_d.base   = new_end_q[mrt_pkg::FIELD_W-1:0];
          mod_d.length = cap_q.length - len_q;
        end else if (middle) begin
          // cut out the middle: keep the head, append the tail, then the carved range
          stat_d = free2 ? mrt_pkg::ST_OK : mrt_pkg::ST_FULL;
          do_mod_d     = free2;
          do_tail_d    = free2;
          do_new_d     = free2;
          mod_d.length = base_q - cap_q.base;
        end else begin
          stat_d = free1 ? mrt_pkg::ST_OK : mrt_pkg::ST_FULL;
          do_mod_d     = free1;
          do_new_d     = free1;
          mod_d.length = cap_q.length - len_q;
        end
      end
      mrt_pkg::MODE_READ: begin
        stat_d = idx_ok ? mrt_pkg::ST_OK : mrt_pkg::ST_INDEX;
      end
      default: begin
        stat_d = mrt_pkg::ST_BADARG;
      end
    endcase
  end

  // cell writes in the write step: modified container, tail, then the new entry
  logic [mrt_pkg::CMP_W-1:0] tail_slot, new_slot;

  assign tail_slot = mrt_pkg::CMP_W'(used_q);
  assign new_slot  = mrt_pkg::CMP_W'(used_q) + mrt_pkg::CMP_W'(do_tail_q);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_we[i] = 1'b0;
      cell_wr[i] = new_e;
      if (state_q == S_WRITE) begin
        if (do_mod_q && (mrt_pkg::CMP_W'(cap_idx_q) == mrt_pkg::CMP_W'(i))) begin
          cell_we[i] = 1'b1;
          cell_wr[i] = mod_q;
        end else if (do_tail_q && (tail_slot == mrt_pkg::CMP_W'(i))) begin
          cell_we[i] = 1'b1;
          cell_wr[i] = tail_q;
        end else if (do_new_q && (new_slot == mrt_pkg::CMP_W'(i))) begin
          cell_we[i] = 1'b1;
        end
      end
    end
  end

  // datapath registers
  logic [mrt_pkg::SUM_W-1:0] req_sum;
  logic                      kind_bad;

  assign req_sum  = {1'b0, base_q} + {1'b0, len_q};
  assign kind_bad = {1'b0, kind_q} >= 4'(mrt_pkg::KIND_COUNT);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mode_q  <= req_i.mode;
        base_q  <= req_i.region_base & mrt_pkg::ADDR_MASK;
        len_q   <= req_i.region_length & mrt_pkg::ADDR_MASK;
        kind_q  <= req_i.region_kind;
        owner_q <= req_i.owner_id;
        idx_q   <= req_i.entry_index;
      end
      S_PREP: begin
        new_end_q <= req_sum;
        badarg_q  <= (len_q == '0) || kind_bad || (65'(req_sum) > mrt_pkg::ADDR_LIMIT);
        ovl_q     <= 1'b0;
        found_q   <= 1'b0;
        rd_q      <= '0;
      end
      S_SCAN: begin
        if (head_used && head_ovl) begin
          ovl_q <= 1'b1;
        end
        // first container in insertion order wins
        if (head_used && head_holds && !found_q) begin
          found_q   <= 1'b1;
          cap_idx_q <= k_q;
          cap_q     <= head;
          cap_end_q <= head_end;
        end
        if (mrt_pkg::CMP_W'(k_q) == mrt_pkg::CMP_W'(idx_q)) begin
          rd_q <= head;
        end
      end
      S_DECIDE: begin
        stat_q    <= stat_d;
        do_mod_q  <= do_mod_d;
        do_tail_q <= do_tail_d;
        do_new_q  <= do_new_d;
        mod_q     <= mod_d;
        tail_q    <= tail_d;
      end
      default: begin
      end
    endcase
  end

  // sequencer, entry count and response register
  logic rsp_free;

  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      k_q          <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_entry_q  <= '0;
      rsp_count_q  <= '0;
    end else begin
      // drop a taken response unless the load step refills the register this cycle
      if (rsp_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          k_q     <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // advance the ring one cell; a full turn restores the order
          k_q <= k_q + 1'b1;
          if (k_q == mrt_pkg::IDX_W'(N - 1)) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          used_q  <= used_q + mrt_pkg::USED_W'(do_tail_q) + mrt_pkg::USED_W'(do_new_q);
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold here until the response register frees up
          if (rsp_free) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= stat_q;
            rsp_count_q  <= mrt_pkg::COUNT_W'(used_q);
            if ((mode_q == mrt_pkg::MODE_READ) && (stat_q == mrt_pkg::ST_OK)) begin
              rsp_entry_q <= rd_q;
            end else begin
              rsp_entry_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.entry_base   = rsp_entry_q.base;
  assign rsp_o.entry_length = rsp_entry_q.length;
  assign rsp_o.entry_kind   = rsp_entry_q.kind;
  assign rsp_o.entry_owner  = rsp_entry_q.owner;
  assign rsp_o.entry_count  = rsp_count_q;

endmodule

### verif/tb_memory_region_table.sv
// Testbench of the memory region table: directed and random transactions against a table mirror.
module tb_memory_region_table;
  import mrt_pkg::*;

  // Mode 3 has no meaning; the block must answer it as a bad argument.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Generous upper bound on the whole run, in time units.
  localparam int RUN_LIMIT = 8_000_000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] length;
    logic [KIND_W-1:0]  kind;
    logic [OWNER_W-1:0] owner;
    logic [INDEX_W-1:0] index;
  } region_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] length;
    logic [KIND_W-1:0]  kind;
    logic [OWNER_W-1:0] owner;
    logic [COUNT_W-1:0] count;
  } region_rsp_t;

  logic clk;
  logic rst_n;

  mrt_req_if req_if ();
  mrt_rsp_if rsp_if ();

  memory_region_table u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Mirror of the region table, advanced once per accepted request transaction.
  entry_t      region_mirror [ENTRIES];
  int unsigned mirror_used;

  region_rsp_t expected_rsps [$];
  int          failures;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  // While clear, random traffic stops appending once the table is two short of full,
  // so the table-full test can start from one free entry.
  bit          allow_fill;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Table mirror
  // ---------------------------------------------------------------------------

  function automatic bit overlaps_any(logic [FIELD_W-1:0] base, logic [FIELD_W-1:0] length);
    logic [64:0] stored_end;
    for (int i = 0; i < mirror_used; i++) begin
      stored_end = 65'(region_mirror[i].base) + 65'(region_mirror[i].length);
      if (65'(base) < stored_end && 65'(region_mirror[i].base) < 65'(base) + 65'(length))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void append_region(logic [FIELD_W-1:0] base, logic [FIELD_W-1:0] length,
                                        logic [KIND_W-1:0] kind, logic [OWNER_W-1:0] owner);
    region_mirror[mirror_used] = '{base: base, length: length, kind: kind, owner: owner};
    mirror_used++;
  endfunction

  function automatic logic [STAT_W-1:0] add_region(logic [FIELD_W-1:0] base,
                                                   logic [FIELD_W-1:0] length,
                                                   logic [KIND_W-1:0] kind,
                                                   logic [OWNER_W-1:0] owner);
    // Overlap wins over a full table.
    if (overlaps_any(base, length)) return ST_OVERLAP;
    if (mirror_used >= ENTRIES) return ST_FULL;
    append_region(base, length, kind, owner);
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] split_region(logic [FIELD_W-1:0] base,
                                                     logic [FIELD_W-1:0] length,
                                                     logic [KIND_W-1:0] kind,
                                                     logic [OWNER_W-1:0] owner);
    logic [64:0] cut_start;
    logic [64:0] cut_end;
    logic [64:0] reg_start;
    logic [64:0] reg_end;
    int unsigned free_slots;
    cut_start = 65'(base);
    cut_end   = 65'(base) + 65'(length);
    for (int i = 0; i < mirror_used; i++) begin
      reg_start  = 65'(region_mirror[i].base);
      reg_end    = reg_start + 65'(region_mirror[i].length);
      free_slots = ENTRIES - mirror_used;
      if (cut_start < reg_start || cut_end > reg_end) continue;
      // Whole region: retype only, owner and count stay.
      if (cut_start == reg_start && cut_end == reg_end) begin
        region_mirror[i].kind = kind;
        return ST_OK;
      end
      if (cut_start == reg_start) begin
        if (free_slots < 1) return ST_FULL;
        region_mirror[i].base   = FIELD_W'(cut_end);
        region_mirror[i].length = region_mirror[i].length - length;
      end else if (cut_end < reg_end) begin
        // Middle cut: the tail goes in first, then the carved range.
        if (free_slots < 2) return ST_FULL;
        append_region(FIELD_W'(cut_end), FIELD_W'(reg_end - cut_end),
                      region_mirror[i].kind, region_mirror[i].owner);
        region_mirror[i].length = FIELD_W'(cut_start - reg_start);
      end else begin
        if (free_slots < 1) return ST_FULL;
        region_mirror[i].length = region_mirror[i].length - length;
      end
      append_region(base, length, kind, owner);
      return ST_OK;
    end
    return ST_NOCONT;
  endfunction

  // Work out the response to one request and advance the mirror.
  function automatic region_rsp_t predict_table(region_req_t r);
    region_rsp_t        rsp;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] length;
    rsp    = '0;
    base   = r.base & ADDR_MASK;
    length = r.length & ADDR_MASK;
    if (r.mode == MODE_ADD || r.mode == MODE_SPLIT) begin
      if (length == '0 || r.kind >= KIND_COUNT || 65'(base) + 65'(length) > ADDR_LIMIT)
        rsp.status = ST_BADARG;
      else if (r.mode == MODE_ADD)
        rsp.status = add_region(base, length, r.kind, r.owner);
      else
        rsp.status = split_region(base, length, r.kind, r.owner);
    end else if (r.mode == MODE_READ) begin
      if (r.index < mirror_used) begin
        rsp.status = ST_OK;
        rsp.base   = region_mirror[r.index].base;
        rsp.length = region_mirror[r.index].length;
        rsp.kind   = region_mirror[r.index].kind;
        rsp.owner  = region_mirror[r.index].owner;
      end else begin
        rsp.status = ST_INDEX;
      end
    end else begin
      rsp.status = ST_BADARG;
    end
    rsp.count = COUNT_W'(mirror_used);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver and response checker
  // ---------------------------------------------------------------------------

  function automatic region_req_t make_req(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] base,
                                           logic [FIELD_W-1:0] length, logic [KIND_W-1:0] kind,
                                           logic [OWNER_W-1:0] owner,
                                           logic [INDEX_W-1:0] index);
    return '{mode: mode, base: base, length: length, kind: kind, owner: owner, index: index};
  endfunction

  // Drive one request at the falling edge, hold it until accepted, record the prediction.
  task automatic send_req(region_req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= r.mode;
    req_if.region_base   <= r.base;
    req_if.region_length <= r.length;
    req_if.region_kind   <= r.kind;
    req_if.owner_id      <= r.owner;
    req_if.entry_index   <= r.index;
    do @(posedge clk); while (!req_if.ready);
    expected_rsps.push_back(predict_table(r));
  endtask

  // Drop valid and hold off until every outstanding response has come back.
  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    region_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("response transaction with no request outstanding");
        failures++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("status", want.status, rsp_if.status);
        check_field("entry_base", want.base, rsp_if.entry_base);
        check_field("entry_length", want.length, rsp_if.entry_length);
        check_field("entry_kind", want.kind, rsp_if.entry_kind);
        check_field("entry_owner", want.owner, rsp_if.entry_owner);
        check_field("entry_count", want.count, rsp_if.entry_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [FIELD_W-1:0] rand48();
    return FIELD_W'({$urandom(), $urandom()});
  endfunction

  // Mostly short ranges, sometimes any 48-bit value (zero included).
  function automatic logic [FIELD_W-1:0] rand_length();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return FIELD_W'($urandom_range(1, 256));
    if (pick < 8) return FIELD_W'($urandom_range(1, 1 << 20));
    return rand48();
  endfunction

  // A well-formed add that lands in free address space.
  function automatic region_req_t fresh_add();
    region_req_t r;
    r = make_req(MODE_ADD, '0, '0, KIND_W'($urandom_range(0, KIND_COUNT - 1)),
                 OWNER_W'($urandom()), INDEX_W'($urandom()));
    do begin
      r.base   = rand48();
      r.length = FIELD_W'($urandom_range(3, 4096));
    end while (65'(r.base) + 65'(r.length) > ADDR_LIMIT || overlaps_any(r.base, r.length));
    return r;
  endfunction

  // One random request, shaped by the mirror so most of them reach the table logic.
  function automatic region_req_t random_req();
    region_req_t        r;
    entry_t             e;
    int unsigned        pick;
    bit                 hold_fill;
    logic [FIELD_W-1:0] off;
    r = make_req(MODE_READ, rand48(), rand_length(),
                 KIND_W'($urandom_range(0, KIND_COUNT - 1)), OWNER_W'($urandom()),
                 INDEX_W'($urandom()));
    pick      = $urandom_range(0, 99);
    hold_fill = !allow_fill && mirror_used >= ENTRIES - 2;
    if (mirror_used == 0) pick = 62;
    if (hold_fill && pick >= 90) pick = 34;
    if (mirror_used != 0) e = region_mirror[$urandom_range(0, mirror_used - 1)];

    if (pick < 34 || (pick >= 86 && pick < 90)) begin
      // Read, mostly of a stored entry.
      if (mirror_used != 0 && $urandom_range(0, 3) != 0)
        r.index = INDEX_W'($urandom_range(0, mirror_used - 1));
    end else if (pick < 54) begin
      // Whole-region retype.
      r.mode   = MODE_SPLIT;
      r.base   = e.base;
      r.length = e.length;
    end else if (pick < 62) begin
      // Add that starts inside a stored region.
      r.mode   = MODE_ADD;
      off      = rand48() % e.length;
      r.base   = e.base + off;
      r.length = FIELD_W'($urandom_range(1, 64));
    end else if (pick < 70) begin
      // Noise over every field.
      r.mode = MODE_W'($urandom_range(0, 3));
      r.kind = KIND_W'($urandom_range(0, 7));
      if (hold_fill && r.mode == MODE_ADD) r.length = '0;
    end else if (pick < 78) begin
      // Split that runs past the end of a region.
      r.mode   = MODE_SPLIT;
      r.base   = e.base + e.length - 1;
      r.length = FIELD_W'($urandom_range(2, 64));
    end else if (pick < 86) begin
      // Bad arguments: zero length, invalid type, or past the address space.
      r.mode = $urandom_range(0, 1) ? MODE_SPLIT : MODE_ADD;
      case ($urandom_range(0, 2))
        0: r.length = '0;
        1: r.kind = KIND_W'($urandom_range(KIND_COUNT, 7));
        default: begin
          r.base   = ADDR_MASK - FIELD_W'($urandom_range(0, 15));
          r.length = FIELD_W'($urandom_range(17, 64));
        end
      endcase
    end else if (pick < 94) begin
      r = fresh_add();
    end else begin
      // Partial split: front, back or middle, falling back to whole when too short.
      r.mode   = MODE_SPLIT;
      r.base   = e.base;
      r.length = e.length;
      case ($urandom_range(0, 2))
        0: if (e.length >= 2) r.length = 1 + rand48() % (e.length - 1);
        1: if (e.length >= 2) begin
          r.length = 1 + rand48() % (e.length - 1);
          r.base   = e.base + e.length - r.length;
        end
        default: if (e.length >= 3) begin
          off      = 1 + rand48() % (e.length - 2);
          r.base   = e.base + off;
          r.length = 1 + rand48() % (e.length - off - 1);
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // Empty table: nothing to read; unused mode with every field at its maximum.
    send_req(make_req(MODE_READ, '0, '0, '0, '0, '0));
    send_req(make_req(MODE_UNUSED, ADDR_MASK, ADDR_MASK, '1, '1, '1));
    // Bad arguments on add.
    send_req(make_req(MODE_ADD, 48'h1000, '0, 3'd1, 8'd1, '0));
    send_req(make_req(MODE_ADD, 48'h1000, 48'h10, 3'd6, 8'd1, '0));
    send_req(make_req(MODE_ADD, 48'h1000, 48'h10, 3'd7, 8'd1, '0));
    send_req(make_req(MODE_ADD, ADDR_MASK, 48'd2, 3'd1, 8'd1, '0));
    // Range that ends exactly at the top of the address space, then the lowest byte.
    send_req(make_req(MODE_ADD, ADDR_MASK - 48'd15, 48'd16, 3'd5, 8'hFF, '0));
    send_req(make_req(MODE_ADD, '0, 48'd1, 3'd0, 8'd0, '0));
    send_req(make_req(MODE_ADD, 48'h1000, 48'h1000, 3'd1, 8'd3, '0));
    // One shared byte is an overlap; touching from below is not.
    send_req(make_req(MODE_ADD, 48'h1FFF, 48'd1, 3'd1, 8'd3, '0));
    send_req(make_req(MODE_ADD, 48'h0FFF, 48'd1, 3'd2, 8'd4, '0));
    // Whole, front, back and middle splits of the same region.
    send_req(make_req(MODE_SPLIT, 48'h1000, 48'h1000, 3'd3, 8'd9, '0));
    send_req(make_req(MODE_SPLIT, 48'h1000, 48'h100, 3'd4, 8'd10, '0));
    send_req(make_req(MODE_SPLIT, 48'h1F00, 48'h100, 3'd0, 8'd11, '0));
    send_req(make_req(MODE_SPLIT, 48'h1400, 48'h100, 3'd5, 8'h80, '0));
    // No container: free space, a range across two neighbors, all but the top byte of the space.
    send_req(make_req(MODE_SPLIT, 48'h5000, 48'd1, 3'd1, 8'd1, '0));
    send_req(make_req(MODE_SPLIT, 48'h13FF, 48'd2, 3'd1, 8'd1, '0));
    send_req(make_req(MODE_SPLIT, '0, ADDR_MASK, 3'd0, 8'd1, '0));
    // Bad arguments on split.
    send_req(make_req(MODE_SPLIT, 48'h1100, '0, 3'd1, 8'd1, '0));
    send_req(make_req(MODE_SPLIT, 48'h1100, 48'h10, 3'd6, 8'd1, '0));
    send_req(make_req(MODE_SPLIT, ADDR_MASK, 48'd2, 3'd1, 8'd1, '0));
    // Reads in range and past the count.
    send_req(make_req(MODE_READ, ADDR_MASK, ADDR_MASK, '1, '1, 4'd0));
    send_req(make_req(MODE_READ, '0, '0, '0, '0, 4'd2));
    send_req(make_req(MODE_READ, '0, '0, '0, '0, 4'd7));
    send_req(make_req(MODE_READ, '0, '0, '0, '0, 4'd8));
    send_req(make_req(MODE_READ, '0, '0, '0, '0, 4'd15));
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_req(random_req());
  endtask

  task automatic test_table_full();
    entry_t e;
    // Fill to one free entry.
    while (mirror_used < ENTRIES - 1) send_req(fresh_add());
    e = region_mirror[mirror_used - 1];
    // A middle cut needs two free entries, a front trim one.
    send_req(make_req(MODE_SPLIT, e.base + 1, 48'd1, 3'd2, 8'd5, '0));
    send_req(make_req(MODE_SPLIT, e.base, 48'd1, 3'd2, 8'd5, '0));
    // Table full now: fresh add, overlapping add, back and middle splits.
    send_req(fresh_add());
    send_req(make_req(MODE_ADD, e.base, 48'd1, 3'd1, 8'd1, '0));
    e = region_mirror[0];
    send_req(make_req(MODE_SPLIT, e.base + e.length - 1, 48'd1, 3'd3, 8'd6, '0));
    send_req(make_req(MODE_SPLIT, e.base + 1, 48'd1, 3'd3, 8'd6, '0));
    // A whole-region retype still works, and the last entry reads back.
    send_req(make_req(MODE_SPLIT, e.base, e.length, 3'd4, 8'd7, '0));
    send_req(make_req(MODE_READ, '0, '0, '0, '0, 4'(ENTRIES - 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.mode          = '0;
    req_if.region_base   = '0;
    req_if.region_length = '0;
    req_if.region_kind   = '0;
    req_if.owner_id      = '0;
    req_if.entry_index   = '0;
    rsp_if.ready         = 1'b0;
    mirror_used          = 0;
    failures             = 0;
    allow_fill           = 1'b0;
    src_idle_pct         = 21;
    sink_idle_pct        = 62;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(240);
    // Hold off the sender until the block has answered everything.
    drain_results();
    test_table_full();
    allow_fill = 1'b1;
    drain_results();

    src_idle_pct  = 62;
    sink_idle_pct = 21;
    test_random(130);
    drain_results();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(130);

    drain_results();
    // Let any stray response show up before the verdict.
    repeat (ENTRIES + 10) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### memory_region_table.f
rtl/mrt_pkg.sv
rtl/mrt_if.sv
rtl/mrt_cell.sv
rtl/memory_region_table.sv
verif/tb_memory_region_table.sv
